[design/lts_pkg.sv]
// Package with the shared types, codes and constants of the lottery task scheduler.
package lts_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int TIME_W = 32;
  localparam int ID_W = 16;
  localparam int TKT_W = 8;
  localparam int DRAW_W = 31;
  localparam int ST_W = 3;

  localparam logic [ST_W-1:0] ST_LOADED     = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL       = 3'd1;
  localparam logic [ST_W-1:0] ST_SCHEDULED  = 3'd2;
  localparam logic [ST_W-1:0] ST_FINISHED   = 3'd3;
  localparam logic [ST_W-1:0] ST_NO_TICKETS = 3'd4;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SCHED = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [ID_W-1:0]   task_id;
    logic [TKT_W-1:0]  tickets;
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] run_length;
    logic [DRAW_W-1:0] draw;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [ID_W-1:0]   winner_id;
    logic [TIME_W-1:0] run_start;
    logic [TIME_W-1:0] run_end;
    logic [TIME_W-1:0] queue_delay;
    logic [TIME_W-1:0] turnaround_time;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_SCAN1, S_CHECK, S_SCAN2, S_TOTAL, S_DIV,
    S_SCAN3, S_RESULT, S_SHIFT, S_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic do_load;
    logic clr_scan;
    logic scan_step;
    logic jump;
    logic clr_acc;
    logic div_start;
    logic div_step;
    logic mk_result;
    logic shift_step;
    logic set_status;
    logic [ST_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic is_sched;
    logic full;
    logic empty;
    logic win_reached;
    logic scan_last;
    logic any_ready;
    logic total_zero;
    logic div_done;
    logic found;
    logic shift_done;
  } stat_t;

endpackage

[design/lts_ram.sv]
// Generic single-port-write RAM with one registered read port.
module lts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[design/lts_datapath.sv]
// Datapath of the lottery task scheduler: task store, time, scans and the divider.
module lts_datapath #(
  parameter int MAX_TASKS = lts_pkg::MAX_TASKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lts_pkg::in_item_t in_item,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  input  lts_pkg::cmd_t     cmd,
  output lts_pkg::stat_t    stat,
  output lts_pkg::out_item_t res
);
  import lts_pkg::*;
  localparam int AW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int SUM_W = TKT_W + CW;
  localparam int ENT_W = ID_W + TKT_W + 2 * TIME_W;

  logic [ENT_W-1:0] rd_data, wr_data;
  logic [AW-1:0] waddr, raddr;
  logic we;

  in_item_t item_r;
  logic [CW-1:0] count_r;
  logic [TIME_W-1:0] now_r, window_r, earliest_r;
  logic [CW-1:0] idx_r;
  logic any_r, found_r, lag_r;
  logic [SUM_W-1:0] acc_r;
  logic [DRAW_W-1:0] rem_r, quo_r;
  logic [5:0] dcnt_r;
  logic [AW-1:0] win_r;
  out_item_t res_r;
  out_item_t stat_res;

  logic [ID_W-1:0] e_id;
  logic [TKT_W-1:0] e_tkt;
  logic [TIME_W-1:0] e_arr, e_run;
  assign {e_id, e_tkt, e_arr, e_run} = rd_data;

  lts_ram #(.WIDTH(ENT_W), .DEPTH(MAX_TASKS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wr_data),
    .raddr(raddr), .rdata(rd_data)
  );

  // The read address runs one ahead; lag_r marks that rd_data holds entry idx_r-1.
  // Once the winner is found its entry is read back for the result.
  assign raddr = found_r ? win_r : idx_r[AW-1:0];
  logic [CW-1:0] prev;
  assign prev = idx_r - CW'(1);
  logic ready_e;
  assign ready_e = e_arr <= now_r;

  always_comb begin
    we = 1'b0;
    waddr = count_r[AW-1:0];
    wr_data = {item_r.task_id, item_r.tickets, item_r.arrival_time, item_r.run_length};
    if (cmd.do_load) begin
      we = 1'b1;
    end else if (cmd.shift_step && lag_r) begin
      we = 1'b1;
      waddr = AW'(prev - CW'(1));
      wr_data = rd_data;
    end
  end

  always_comb begin
    stat_res = '0;
    stat_res.status = cmd.status;
  end

  logic [SUM_W+1:0] trial;
  assign trial = {1'b0, rem_r[SUM_W-1:0], quo_r[DRAW_W-1]} - {2'b0, acc_r};
  logic [SUM_W-1:0] acc_add;
  assign acc_add = acc_r + SUM_W'(e_tkt);
  logic [TIME_W:0] endt_w;
  assign endt_w = {1'b0, now_r} + {1'b0, e_run};
  logic [TIME_W-1:0] endt;
  assign endt = endt_w[TIME_W] ? '1 : endt_w[TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      now_r <= '0;
      window_r <= '1;
    end else begin
      if (cfg_we) window_r <= cfg_wdata;
      if (cmd.do_load) count_r <= count_r + CW'(1);
      if (cmd.jump && earliest_r > now_r) now_r <= earliest_r;
      if (cmd.mk_result) begin
        now_r <= endt;
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) item_r <= in_item;
    if (cmd.clr_scan) begin
      idx_r <= cmd.mk_result ? CW'(win_r) + CW'(1) : '0;
      lag_r <= 1'b0;
      any_r <= 1'b0;
      found_r <= 1'b0;
      earliest_r <= window_r;
      if (cmd.clr_acc) acc_r <= '0;
    end
    if (cmd.scan_step || cmd.shift_step) begin
      idx_r <= idx_r + CW'(1);
      lag_r <= 1'b1;
      if (lag_r && cmd.scan_step) begin
        if (ready_e) any_r <= 1'b1;
        if (e_arr < earliest_r) earliest_r <= e_arr;
        if (ready_e && !found_r) begin
          acc_r <= acc_add;
          if (cmd.clr_acc && SUM_W'(rem_r) < acc_add) begin
            found_r <= 1'b1;
            win_r <= AW'(prev);
          end
        end
      end
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= item_r.draw;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 6'd1;
      if (!trial[SUM_W+1]) begin
        rem_r <= DRAW_W'(trial[SUM_W-1:0]);
        quo_r <= {quo_r[DRAW_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DRAW_W-2:0], quo_r[DRAW_W-1]};
        quo_r <= {quo_r[DRAW_W-2:0], 1'b0};
      end
    end
    if (cmd.mk_result) begin
      res_r.status <= ST_SCHEDULED;
      res_r.winner_id <= e_id;
      res_r.run_start <= now_r;
      res_r.run_end <= endt;
      res_r.queue_delay <= now_r - e_arr;
      res_r.turnaround_time <= endt - e_arr;
    end else if (cmd.set_status) begin
      res_r <= stat_res;
    end
  end

  assign res = res_r;
  assign stat.is_sched = item_r.cmd == CMD_SCHED;
  assign stat.full = count_r == CW'(MAX_TASKS);
  assign stat.empty = count_r == '0;
  assign stat.win_reached = now_r >= window_r;
  assign stat.scan_last = lag_r && idx_r == count_r;
  assign stat.any_ready = any_r;
  assign stat.total_zero = acc_r == '0;
  assign stat.div_done = dcnt_r == 6'(DRAW_W);
  assign stat.found = found_r;
  assign stat.shift_done = idx_r > count_r;
endmodule

[design/lts_ctrl.sv]
// Controller state machine of the lottery task scheduler.
module lts_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  lts_pkg::stat_t stat,
  output lts_pkg::cmd_t  cmd
);
  import lts_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.set_status = 1'b1;
        state_nxt = S_OUT;
        if (!stat.is_sched) begin
          if (stat.full) cmd.status = ST_FULL;
          else begin
            cmd.status = ST_LOADED;
            cmd.do_load = 1'b1;
          end
        end else if (stat.empty || stat.win_reached) cmd.status = ST_FINISHED;
        else begin
          cmd.set_status = 1'b0;
          cmd.clr_scan = 1'b1;
          state_nxt = S_SCAN1;
        end
      end
      S_SCAN1: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.jump = !stat.any_ready;
        cmd.clr_scan = 1'b1;
        cmd.clr_acc = 1'b1;
        state_nxt = S_SCAN2;
      end
      S_SCAN2: begin
        if (stat.win_reached) begin
          cmd.set_status = 1'b1;
          cmd.status = ST_FINISHED;
          state_nxt = S_OUT;
        end else begin
          cmd.scan_step = 1'b1;
          if (stat.scan_last) state_nxt = S_TOTAL;
        end
      end
      S_TOTAL: begin
        if (stat.total_zero) begin
          cmd.set_status = 1'b1;
          cmd.status = ST_NO_TICKETS;
          state_nxt = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          cmd.div_step = 1'b0;
          cmd.clr_scan = 1'b1;
          cmd.clr_acc = 1'b1;
          state_nxt = S_SCAN3;
        end
      end
      S_SCAN3: begin
        cmd.scan_step = 1'b1;
        cmd.clr_acc = 1'b1;
        if (stat.found) begin
          cmd.scan_step = 1'b0;
          cmd.clr_scan = 1'b0;
          state_nxt = S_RESULT;
        end else if (stat.shift_done) begin
          cmd.scan_step = 1'b0;
          cmd.set_status = 1'b1;
          cmd.status = ST_NO_TICKETS;
          state_nxt = S_OUT;
        end
      end
      S_RESULT: begin
        cmd.mk_result = 1'b1;
        cmd.clr_scan = 1'b1;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (stat.shift_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

[design/lottery_task_scheduler_unit.sv]
// Top level of the lottery task scheduler.
// Input transactions carry a load or a schedule command on in_valid/in_ready;
// one result transaction per input leaves on out_valid/out_ready.
// The user must write the time window register through cfg_we and cfg_wdata only while
// idle; the block itself does not enforce this. A schedule walks the task table in
// one RAM read per cycle: a readiness scan, a ticket sum scan, a 31-step
// restoring division for the draw remainder, a winner scan and a compaction
// pass over the later slots.
// One transaction is in flight at a time; the input is refused until its
// result has been taken. A stalled receiver holds the result steady.
// Synchronous reset empties the table, clears the time and sets the window
// to its maximum; the task store itself is not cleared.
module lottery_task_scheduler_unit #(
  parameter int MAX_TASKS = lts_pkg::MAX_TASKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lts_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);
  import lts_pkg::*;
  cmd_t cmd;
  stat_t stat;

  lts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  lts_datapath #(.MAX_TASKS(MAX_TASKS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_data), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata), .cmd(cmd), .stat(stat), .res(out_data)
  );

`ifndef NO_ASSERTIONS
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("input and output open together");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_NO_TICKETS)
    else $error("bad status");
`endif
endmodule
